FILE: src/mcd_pkg.sv
// Shared types and constants for the multi-channel change debouncer.
package mcd_pkg;

  localparam int unsigned LEVELS_W  = 16;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned OUT_W     = 2 * LEVELS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TICKS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLE = 1'b1;

  localparam logic [TICK_W-1:0]   FILTER_TICKS_RST   = 8'd5;
  localparam logic [LEVELS_W-1:0] CHANNEL_ENABLE_RST = 16'h0000;

  // What one channel lane hands to the merging stage for one tick.
  typedef struct packed {
    logic report;
    logic level;
  } lane_res_t;

endpackage

FILE: src/mcd_lane.sv
// One debounce lane: filter state, tick counter and committed level of a channel.
module mcd_lane
  import mcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  logic              primed_i,
  input  logic              sample_i,
  input  logic              enable_i,
  input  logic [TICK_W-1:0] filter_ticks_i,
  output lane_res_t         res_o
);

  logic              filtering_q, filtering_d;
  logic [TICK_W-1:0] count_q, count_d;
  logic              level_q, level_d;
  logic              report;
  logic              diff;
  logic [TICK_W-1:0] count_inc;

  assign diff      = sample_i ^ level_q;
  assign count_inc = count_q + TICK_W'(1);

  always_comb begin
    filtering_d = filtering_q;
    count_d     = count_q;
    level_d     = level_q;
    report      = 1'b0;
    if (!primed_i) begin
      // The first tick after reset only captures the level.
      level_d = sample_i;
    end else if (!filtering_q) begin
      if (diff) begin
        filtering_d = 1'b1;
        count_d     = '0;
      end
    end else begin
      count_d = count_inc;
      if (count_inc >= filter_ticks_i) begin
        filtering_d = 1'b0;
        if (diff && enable_i) begin
          report  = 1'b1;
          level_d = sample_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filtering_q <= 1'b0;
      count_q     <= '0;
      level_q     <= 1'b0;
    end else if (tick_i) begin
      filtering_q <= filtering_d;
      count_q     <= count_d;
      level_q     <= level_d;
    end
  end

  assign res_o.report = report;
  assign res_o.level  = level_d;

endmodule

FILE: src/mcd_merge.sv
// Merging stage: gathers the lane results into one output beat and holds it.
module mcd_merge
  import mcd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  input  lane_res_t [LEVELS_W-1:0] lane_res_i,
  output logic                   free_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_W-1:0]       m_axis_tdata
);

  logic                valid_q, valid_d;
  logic [OUT_W-1:0]    data_q;
  logic [LEVELS_W-1:0] report_mask;
  logic [LEVELS_W-1:0] committed;

  always_comb begin
    for (int i = 0; i < LEVELS_W; i++) begin
      report_mask[i] = lane_res_i[i].report;
      committed[i]   = lane_res_i[i].level;
    end
  end

  // The held beat can be replaced in the same cycle it is taken.
  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (tick_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      data_q <= {committed, report_mask};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

FILE: src/multi_channel_change_debouncer.sv
// Top level of the multi-channel change debouncer: config registers, lanes and output beat.
//
//   Channel   Direction  Payload (low bit first)                 Handshake
//   s_axis    in         sampled_levels[15:0]                    tvalid/tready
//   m_axis    out        report_mask[15:0], committed_levels[15:0] tvalid/tready
//   cfg       in         0: filter_ticks[7:0], 1: channel_enable  cfg_we_i, no wait
//
// Every channel has its own lane, so one sample beat is taken each cycle while the output
// register can take it, and its result appears in the output register in the following cycle.
// A new beat is accepted whenever the output register is empty or being drained.
// Reset sets filter_ticks to 5, clears the enable mask and all lane state; the first
// beat after reset captures the committed levels and reports nothing.
module multi_channel_change_debouncer
  import mcd_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [LEVELS_W-1:0]  s_axis_tdata,   // sampled_levels[15:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,   // report_mask[15:0], committed_levels[31:16]
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [TICK_W-1:0]         filter_ticks_q;
  logic [LEVELS_W-1:0]       channel_enable_q;
  logic                      primed_q;
  logic                      tick;
  logic                      free;
  lane_res_t [LEVELS_W-1:0]  lane_res;

  assign s_axis_tready = free;
  assign tick          = s_axis_tvalid && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_ticks_q   <= FILTER_TICKS_RST;
      channel_enable_q <= CHANNEL_ENABLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER_TICKS:   filter_ticks_q   <= cfg_data_i[TICK_W-1:0];
        CFG_CHANNEL_ENABLE: channel_enable_q <= cfg_data_i[LEVELS_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
    end else if (tick) begin
      primed_q <= 1'b1;
    end
  end

  for (genvar g = 0; g < LEVELS_W; g++) begin : g_lane
    if (g < CHANNELS) begin : g_used
      mcd_lane u_lane (
        .clk_i          (clk_i),
        .rst_ni         (rst_ni),
        .tick_i         (tick),
        .primed_i       (primed_q),
        .sample_i       (s_axis_tdata[g]),
        .enable_i       (channel_enable_q[g]),
        .filter_ticks_i (filter_ticks_q),
        .res_o          (lane_res[g])
      );
    end else begin : g_unused
      assign lane_res[g] = '0;
    end
  end

  mcd_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .lane_res_i    (lane_res),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
